[rtl/pdwe_pkg.sv]
package pdwe_pkg;

  localparam int QUERY_DEPTH    = 65536;
  localparam int SUBJECT_BYTES  = 65536;
  localparam int BASES_PER_BYTE = 4;

  localparam int QUERY_AW = $clog2(QUERY_DEPTH);
  localparam int SUBJ_AW  = $clog2(SUBJECT_BYTES);

  // running positions: seed offsets plus table word length plus extension
  localparam int QPOS_W = 17;
  localparam int SPOS_W = 19;

  localparam logic [5:0] MAX_EXT = 6'd63;

  localparam logic [1:0] REQ_QWRITE = 2'd0;
  localparam logic [1:0] REQ_SWRITE = 2'd1;
  localparam logic [1:0] REQ_HIT    = 2'd2;

  localparam logic [1:0] CFG_WORD_LEN  = 2'd0;
  localparam logic [1:0] CFG_TABLE_LEN = 2'd1;
  localparam logic [1:0] CFG_SUBJ_LEN  = 2'd2;
  localparam logic [1:0] CFG_SCAN_LIM  = 2'd3;

  localparam logic [6:0]  WORD_LEN_RST  = 7'd28;
  localparam logic [4:0]  TABLE_LEN_RST = 5'd11;

  typedef struct packed {
    logic [6:0]  word_len;
    logic [4:0]  table_len;
    logic [18:0] subject_length;
    logic [18:0] scan_limit;
  } cfg_t;

  typedef struct packed {
    logic [SPOS_W-1:0] spos;
    logic [QPOS_W-1:0] qpos;
  } rd_pos_t;

  typedef struct packed {
    logic        valid;
    logic        kept;
    logic [15:0] start_q;
    logic [17:0] start_s;
    logic [5:0]  left;
  } result_t;

endpackage

[rtl/pdwe_ram.sv]
module pdwe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/pdwe_base_cmp.sv]
module pdwe_base_cmp import pdwe_pkg::*; (
  input  logic                clk,
  input  rd_pos_t             pos,
  output logic [QUERY_AW-1:0] q_raddr,
  output logic [SUBJ_AW-1:0]  s_raddr,
  input  logic [7:0]          q_rdata,
  input  logic [7:0]          s_rdata,
  output logic                base_match
);

  logic [31:0] q_idx;
  logic [31:0] s_idx;
  logic        in_range;
  logic        in_range_r;
  logic [1:0]  sel_r;
  logic [1:0]  sbase;

  // subject byte index is the base position over four
  assign q_idx    = 32'(pos.qpos);
  assign s_idx    = 32'(pos.spos >> 2);
  assign in_range = (q_idx < 32'(QUERY_DEPTH)) && (s_idx < 32'(SUBJECT_BYTES));
  assign q_raddr  = q_idx[QUERY_AW-1:0];
  assign s_raddr  = s_idx[SUBJ_AW-1:0];

  always_ff @(posedge clk) begin
    in_range_r <= in_range;
    sel_r      <= pos.spos[1:0];
  end

  // first base of a byte sits in the top two bits
  assign sbase      = 2'(s_rdata >> {~sel_r, 1'b0});
  assign base_match = in_range_r && ({6'd0, sbase} == q_rdata);

endmodule

[rtl/pdwe_seq.sv]
module pdwe_seq import pdwe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [15:0] go_q_off,
  input  logic [17:0] go_s_off,
  input  cfg_t        cfg,
  output logic        busy,
  output rd_pos_t     rd_pos,
  input  logic        base_match,
  output result_t     res
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SETUP = 7'b0000010,
    S_LRD   = 7'b0000100,
    S_LCMP  = 7'b0001000,
    S_RCHK  = 7'b0010000,
    S_RRD   = 7'b0100000,
    S_RCMP  = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [15:0]       q_off_r, q_off_nxt;
  logic [17:0]       s_off_r, s_off_nxt;
  logic [5:0]        ext_r, ext_nxt;
  logic [5:0]        left_r, left_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [5:0]        need_r, need_nxt;
  logic [SPOS_W-1:0] spos_r, spos_nxt;
  logic [QPOS_W-1:0] qpos_r, qpos_nxt;
  result_t           res_r, res_nxt;

  logic              step_down;
  logic [SPOS_W-1:0] spos_step;
  logic [QPOS_W-1:0] qpos_step;
  logic [6:0]        len_diff;
  logic [5:0]        ext_calc;
  logic [5:0]        need_calc;
  logic [SPOS_W-1:0] sp_right;
  logic [19:0]       right_end;

  // one shared +/-1 step for both positions
  assign step_down = (state_r == S_LCMP);
  assign spos_step = step_down ? spos_r - 1'b1 : spos_r + 1'b1;
  assign qpos_step = step_down ? qpos_r - 1'b1 : qpos_r + 1'b1;

  assign len_diff  = cfg.word_len - 7'(cfg.table_len);
  always_comb begin
    if (cfg.word_len <= 7'(cfg.table_len)) begin
      ext_calc = 6'd0;
    end else if (len_diff > 7'(MAX_EXT)) begin
      ext_calc = MAX_EXT;
    end else begin
      ext_calc = len_diff[5:0];
    end
  end

  assign need_calc = ext_r - left_r;
  assign sp_right  = SPOS_W'(s_off_r) + SPOS_W'(cfg.table_len);
  assign right_end = 20'(sp_right) + 20'(need_calc);

  always_comb begin
    state_nxt = state_r;
    q_off_nxt = q_off_r;
    s_off_nxt = s_off_r;
    ext_nxt   = ext_r;
    left_nxt  = left_r;
    cnt_nxt   = cnt_r;
    need_nxt  = need_r;
    spos_nxt  = spos_r;
    qpos_nxt  = qpos_r;
    res_nxt   = res_r;
    res_nxt.valid = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (go) begin
          q_off_nxt = go_q_off;
          s_off_nxt = go_s_off;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        ext_nxt  = ext_calc;
        left_nxt = 6'd0;
        spos_nxt = SPOS_W'(s_off_r) - 1'b1;
        qpos_nxt = QPOS_W'(q_off_r) - 1'b1;
        if (19'(s_off_r) > cfg.subject_length) begin
          res_nxt   = '{valid: 1'b1, kept: 1'b0, start_q: '0, start_s: '0, left: '0};
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_LRD;
        end
      end
      S_LRD: begin
        // read address is on the ram this cycle
        if ((left_r < ext_r) && (18'(left_r) < s_off_r) && (16'(left_r) < q_off_r)) begin
          state_nxt = S_LCMP;
        end else begin
          state_nxt = S_RCHK;
        end
      end
      S_LCMP: begin
        if (base_match) begin
          left_nxt  = left_r + 1'b1;
          spos_nxt  = spos_step;
          qpos_nxt  = qpos_step;
          state_nxt = S_LRD;
        end else begin
          state_nxt = S_RCHK;
        end
      end
      S_RCHK: begin
        if (left_r >= ext_r) begin
          res_nxt   = '{valid: 1'b1, kept: 1'b1, start_q: q_off_r - 16'(left_r),
                        start_s: s_off_r - 18'(left_r), left: left_r};
          state_nxt = S_IDLE;
        end else if (right_end > 20'(cfg.scan_limit)) begin
          res_nxt   = '{valid: 1'b1, kept: 1'b0, start_q: '0, start_s: '0, left: '0};
          state_nxt = S_IDLE;
        end else begin
          need_nxt  = need_calc;
          cnt_nxt   = 6'd0;
          spos_nxt  = sp_right;
          qpos_nxt  = QPOS_W'(q_off_r) + QPOS_W'(cfg.table_len);
          state_nxt = S_RRD;
        end
      end
      S_RRD: begin
        if (cnt_r < need_r) begin
          state_nxt = S_RCMP;
        end else begin
          res_nxt   = '{valid: 1'b1, kept: 1'b1, start_q: q_off_r - 16'(left_r),
                        start_s: s_off_r - 18'(left_r), left: left_r};
          state_nxt = S_IDLE;
        end
      end
      S_RCMP: begin
        if (base_match) begin
          cnt_nxt   = cnt_r + 1'b1;
          spos_nxt  = spos_step;
          qpos_nxt  = qpos_step;
          state_nxt = S_RRD;
        end else begin
          res_nxt   = '{valid: 1'b1, kept: 1'b0, start_q: '0, start_s: '0, left: '0};
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      res_r.valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      res_r.valid <= res_nxt.valid;
    end
    q_off_r       <= q_off_nxt;
    s_off_r       <= s_off_nxt;
    ext_r         <= ext_nxt;
    left_r        <= left_nxt;
    cnt_r         <= cnt_nxt;
    need_r        <= need_nxt;
    spos_r        <= spos_nxt;
    qpos_r        <= qpos_nxt;
    res_r.kept    <= res_nxt.kept;
    res_r.start_q <= res_nxt.start_q;
    res_r.start_s <= res_nxt.start_s;
    res_r.left    <= res_nxt.left;
  end

  assign busy        = (state_r != S_IDLE);
  assign rd_pos.spos = spos_r;
  assign rd_pos.qpos = qpos_r;
  assign res         = res_r;

endmodule

[rtl/packed_dna_word_extender.sv]
// timing: a seed past the subject end is answered from the setup state; otherwise each base
//   compare passes a read state and a compare state, and each walk that stops without a
//   mismatch adds a final read state; each base compare waits on the registered store read;
//   the next item is taken at the edge that takes the result
// reset: synchronous active-low rst_n clears the sequencer and the result strobe and loads
//   the register defaults; store contents are undefined until written; results cannot stall
module packed_dna_word_extender import pdwe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,

  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_query_addr,
  input  logic [7:0]  in_query_base,
  input  logic [15:0] in_subject_addr,
  input  logic [7:0]  in_subject_byte,
  input  logic [15:0] in_hit_query_offset,
  input  logic [17:0] in_hit_subject_offset,

  // result channel, one-cycle strobe
  output logic        out_valid,
  output logic        out_hit_kept,
  output logic [15:0] out_start_query_offset,
  output logic [17:0] out_start_subject_offset,
  output logic [5:0]  out_left_extension,

  // register writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [18:0] cfg_wdata
);

  cfg_t                cfg_r;
  logic                accept;
  logic                hit_go;
  logic [31:0]         qw_idx;
  logic [31:0]         sw_idx;
  logic                q_we;
  logic                s_we;
  logic [QUERY_AW-1:0] q_raddr;
  logic [SUBJ_AW-1:0]  s_raddr;
  logic [7:0]          q_rdata;
  logic [7:0]          s_rdata;
  rd_pos_t             rd_pos;
  logic                base_match;
  result_t             res;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.word_len       <= WORD_LEN_RST;
      cfg_r.table_len      <= TABLE_LEN_RST;
      cfg_r.subject_length <= '0;
      cfg_r.scan_limit     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WORD_LEN:  cfg_r.word_len       <= cfg_wdata[6:0];
        CFG_TABLE_LEN: cfg_r.table_len      <= cfg_wdata[4:0];
        CFG_SUBJ_LEN:  cfg_r.subject_length <= cfg_wdata;
        CFG_SCAN_LIM:  cfg_r.scan_limit     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign accept = start && !busy;
  assign hit_go = accept && (in_req_type == REQ_HIT);

  // store writes land in the accept cycle; out-of-range indexes are dropped
  assign qw_idx = 32'(in_query_addr);
  assign sw_idx = 32'(in_subject_addr);
  assign q_we   = accept && (in_req_type == REQ_QWRITE) && (qw_idx < 32'(QUERY_DEPTH));
  assign s_we   = accept && (in_req_type == REQ_SWRITE) && (sw_idx < 32'(SUBJECT_BYTES));

  // query store, one base code per byte
  pdwe_ram #(
    .WIDTH (8),
    .DEPTH (QUERY_DEPTH)
  ) u_query_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (qw_idx[QUERY_AW-1:0]),
    .wdata (in_query_base),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // subject store, four packed bases per byte
  pdwe_ram #(
    .WIDTH (8),
    .DEPTH (SUBJECT_BYTES)
  ) u_subject_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (sw_idx[SUBJ_AW-1:0]),
    .wdata (in_subject_byte),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // shared base compare: address, range check, unpack and match
  pdwe_base_cmp u_cmp (
    .clk        (clk),
    .pos        (rd_pos),
    .q_raddr    (q_raddr),
    .s_raddr    (s_raddr),
    .q_rdata    (q_rdata),
    .s_rdata    (s_rdata),
    .base_match (base_match)
  );

  // sequencer: subject end check, left walk, right bound check, right walk
  pdwe_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (hit_go),
    .go_q_off   (in_hit_query_offset),
    .go_s_off   (in_hit_subject_offset),
    .cfg        (cfg_r),
    .busy       (busy),
    .rd_pos     (rd_pos),
    .base_match (base_match),
    .res        (res)
  );

  assign out_valid                = res.valid;
  assign out_hit_kept             = res.kept;
  assign out_start_query_offset   = res.start_q;
  assign out_start_subject_offset = res.start_s;
  assign out_left_extension       = res.left;

endmodule

[sim/tb_packed_dna_word_extender.sv]
module tb_packed_dna_word_extender;
  import pdwe_pkg::*;

  // request code the block has to ignore
  localparam logic [1:0] REQ_NONE = 2'd3;

  // every accepted item counts, store fills included
  localparam int TOTAL_ITEMS  = 550;
  localparam int MIN_RANDOM   = 300;
  localparam int PHASES       = 6;
  // settle time, rounded up from a worst-case seed
  localparam int SETTLE       = 300;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PRINT_CAP    = 40;

  // one command item with every field of the input channel
  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] query_addr;
    logic [7:0]  query_base;
    logic [15:0] subject_addr;
    logic [7:0]  subject_byte;
    logic [15:0] hit_q;
    logic [17:0] hit_s;
  } cmd_t;

  // outcome of one seed hit
  typedef struct packed {
    logic        kept;
    logic [15:0] q;
    logic [17:0] s;
    logic [5:0]  left;
  } word_t;

  // one row of the directed table: a register write or a command item
  typedef struct {
    bit          is_reg;
    logic [1:0]  reg_idx;
    logic [18:0] reg_val;
    cmd_t        cmd;
    bit          typed;
    word_t       want;
  } step_t;

  // outcome of a single base compare
  typedef enum logic [1:0] {CMP_DIFF, CMP_SAME, CMP_UNWRITTEN} cmp_e;

  localparam word_t DROPPED = '0;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_req_type;
  logic [15:0] in_query_addr;
  logic [7:0]  in_query_base;
  logic [15:0] in_subject_addr;
  logic [7:0]  in_subject_byte;
  logic [15:0] in_hit_query_offset;
  logic [17:0] in_hit_subject_offset;
  logic        out_valid;
  logic        out_hit_kept;
  logic [15:0] out_start_query_offset;
  logic [17:0] out_start_subject_offset;
  logic [5:0]  out_left_extension;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [18:0] cfg_wdata;

  // mirror of the block's stores, with a written flag per entry
  logic [7:0] query_mem   [QUERY_DEPTH];
  logic [7:0] subject_mem [SUBJECT_BYTES];
  bit         q_written   [QUERY_DEPTH];
  bit         s_written   [SUBJECT_BYTES];

  // mirror of the registers, reset values
  int unsigned word_len_r  = 28;
  int unsigned table_len_r = 11;
  int unsigned subj_len_r  = 0;
  int unsigned scan_lim_r  = 0;

  // seed outcomes waiting for their result strobe, oldest first
  word_t pending_words[$];
  step_t plan[$];

  // first compare that would touch an entry never written
  int unsigned gap_spos;
  int unsigned gap_qpos;

  int idle_pct  = 34;
  int match_pct = 95;
  int errors    = 0;
  int items_done = 0;
  int words_seen = 0;
  int kept_seen  = 0;
  int reg_writes = 0;
  int deepest_left = 0;
  int unsigned cycle_count = 0;

  packed_dna_word_extender DUT (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .start                    (start),
    .busy                     (busy),
    .in_req_type              (in_req_type),
    .in_query_addr            (in_query_addr),
    .in_query_base            (in_query_base),
    .in_subject_addr          (in_subject_addr),
    .in_subject_byte          (in_subject_byte),
    .in_hit_query_offset      (in_hit_query_offset),
    .in_hit_subject_offset    (in_hit_subject_offset),
    .out_valid                (out_valid),
    .out_hit_kept             (out_hit_kept),
    .out_start_query_offset   (out_start_query_offset),
    .out_start_subject_offset (out_start_subject_offset),
    .out_left_extension       (out_left_extension),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_wdata                (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               pending_words.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // one line per mismatch, capped so a broken block cannot flood the log
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (errors < PRINT_CAP)
      $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  // every field random, so unused fields toggle too
  function automatic cmd_t scrambled_cmd();
    cmd_t c;
    c.req          = 2'($urandom);
    c.query_addr   = 16'($urandom);
    c.query_base   = 8'($urandom);
    c.subject_addr = 16'($urandom);
    c.subject_byte = 8'($urandom);
    c.hit_q        = 16'($urandom);
    c.hit_s        = 18'($urandom);
    return c;
  endfunction

  function automatic word_t kept_at(input logic [15:0] q, input logic [17:0] s);
    word_t w;
    w.kept = 1'b1;
    w.q    = q;
    w.s    = s;
    w.left = '0;
    return w;
  endfunction

  function automatic void plan_reg(input logic [1:0] idx, input logic [18:0] val);
    step_t st;
    st.is_reg  = 1'b1;
    st.reg_idx = idx;
    st.reg_val = val;
    st.cmd     = scrambled_cmd();
    st.typed   = 1'b0;
    st.want    = DROPPED;
    plan.insert(plan.size(), st);
  endfunction

  // a and b are address and data for writes, query and subject offset for hits
  function automatic void plan_cmd(input logic [1:0] req, input int unsigned a,
                                   input int unsigned b, input bit typed,
                                   input word_t want);
    step_t st;
    st.is_reg  = 1'b0;
    st.reg_idx = '0;
    st.reg_val = '0;
    st.cmd     = scrambled_cmd();
    st.cmd.req = req;
    case (req)
      REQ_QWRITE: begin
        st.cmd.query_addr = 16'(a);
        st.cmd.query_base = 8'(b);
      end
      REQ_SWRITE: begin
        st.cmd.subject_addr = 16'(a);
        st.cmd.subject_byte = 8'(b);
      end
      REQ_HIT: begin
        st.cmd.hit_q = 16'(a);
        st.cmd.hit_s = 18'(b);
      end
      default: ;
    endcase
    st.typed = typed;
    st.want  = want;
    plan.insert(plan.size(), st);
  endfunction

  // 2-bit subject base, first base of a byte in the top bits
  function automatic logic [1:0] subj_base(input int unsigned spos);
    logic [7:0] b;
    b = subject_mem[spos / BASES_PER_BYTE];
    return b[(3 - spos % BASES_PER_BYTE) * 2 +: 2];
  endfunction

  // bases outside either store never match and are never read
  function automatic cmp_e compare_base(input int unsigned spos, input int unsigned qpos);
    if (spos / BASES_PER_BYTE >= SUBJECT_BYTES || qpos >= QUERY_DEPTH)
      return CMP_DIFF;
    if (!q_written[qpos] || !s_written[spos / BASES_PER_BYTE]) begin
      gap_spos = spos;
      gap_qpos = qpos;
      return CMP_UNWRITTEN;
    end
    return (query_mem[qpos] == {6'd0, subj_base(spos)}) ? CMP_SAME : CMP_DIFF;
  endfunction

  // exact word extension of one seed; returns 0 if it would read an unwritten entry
  function automatic bit extend_seed(input logic [15:0] q_off, input logic [17:0] s_off,
                                     output word_t res);
    int unsigned needed;
    int unsigned left;
    int unsigned right;
    int unsigned rest;
    int unsigned sp;
    int unsigned qp;
    cmp_e c;
    res = DROPPED;
    // seed past the subject end
    if (s_off > subj_len_r)
      return 1'b1;
    needed = (word_len_r > table_len_r) ? word_len_r - table_len_r : 0;
    // long word saturates
    if (needed > MAX_EXT)
      needed = MAX_EXT;
    // leftward, stopping at the start of either sequence
    left = 0;
    while (left < needed && left < s_off && left < q_off) begin
      c = compare_base(s_off - left - 1, q_off - left - 1);
      if (c == CMP_UNWRITTEN)
        return 1'b0;
      if (c == CMP_DIFF)
        break;
      left++;
    end
    if (left < needed) begin
      // rightward from just past the seed, bounded by the scan limit
      sp   = s_off + table_len_r;
      qp   = q_off + table_len_r;
      rest = needed - left;
      if (sp + rest > scan_lim_r)
        return 1'b1;
      right = 0;
      while (right < rest) begin
        c = compare_base(sp + right, qp + right);
        if (c == CMP_UNWRITTEN)
          return 1'b0;
        if (c == CMP_DIFF)
          break;
        right++;
      end
      if (right < rest)
        return 1'b1;
    end
    res.kept = 1'b1;
    res.q    = 16'(q_off - left);
    res.s    = 18'(s_off - left);
    res.left = 6'(left);
    return 1'b1;
  endfunction

  // present one item, hold it until start meets a low busy, then update the mirror
  task automatic send_item(input cmd_t c, input bit typed, input word_t want);
    word_t w;
    cfg_we <= 1'b0;
    // sender gaps, one coin per cycle
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start                 <= 1'b1;
    in_req_type           <= c.req;
    in_query_addr         <= c.query_addr;
    in_query_base         <= c.query_base;
    in_subject_addr       <= c.subject_addr;
    in_subject_byte       <= c.subject_byte;
    in_hit_query_offset   <= c.hit_q;
    in_hit_subject_offset <= c.hit_s;
    do @(posedge clk); while (busy !== 1'b0);
    // accepted at this edge
    items_done++;
    case (c.req)
      REQ_QWRITE: begin
        query_mem[c.query_addr] = c.query_base;
        q_written[c.query_addr] = 1'b1;
      end
      REQ_SWRITE: begin
        subject_mem[c.subject_addr] = c.subject_byte;
        s_written[c.subject_addr]   = 1'b1;
      end
      REQ_HIT: begin
        if (typed) begin
          pending_words.insert(pending_words.size(), want);
        end else begin
          void'(extend_seed(c.hit_q, c.hit_s, w));
          pending_words.insert(pending_words.size(), w);
        end
      end
      default: ;
    endcase
  endtask

  // fill every entry the seed would read before sending it, mostly with matching bases
  task automatic send_hit(input cmd_t c, input bit typed, input word_t want);
    word_t w;
    cmd_t f;
    int unsigned sh;
    while (!extend_seed(c.hit_q, c.hit_s, w)) begin
      f = scrambled_cmd();
      if (!q_written[gap_qpos]) begin
        f.req        = REQ_QWRITE;
        f.query_addr = 16'(gap_qpos);
        if (s_written[gap_spos / BASES_PER_BYTE] && $urandom_range(99) < match_pct)
          f.query_base = {6'd0, subj_base(gap_spos)};
        else if ($urandom_range(99) < 5)
          f.query_base = 8'($urandom);
        else
          f.query_base = 8'($urandom_range(3));
      end else begin
        f.req          = REQ_SWRITE;
        f.subject_addr = 16'(gap_spos / BASES_PER_BYTE);
        sh             = (3 - gap_spos % BASES_PER_BYTE) * 2;
        if ($urandom_range(99) < match_pct && query_mem[gap_qpos] < 4)
          f.subject_byte[sh +: 2] = query_mem[gap_qpos][1:0];
      end
      send_item(f, 1'b0, DROPPED);
    end
    send_item(c, typed, want);
  endtask

  // drain all results before touching registers
  task automatic wait_idle();
    start  <= 1'b0;
    cfg_we <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [18:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    reg_writes++;
    case (idx)
      CFG_WORD_LEN:  word_len_r  = val[6:0];
      CFG_TABLE_LEN: table_len_r = val[4:0];
      CFG_SUBJ_LEN:  subj_len_r  = val;
      CFG_SCAN_LIM:  scan_lim_r  = val;
      default: ;
    endcase
  endtask

  // result checker, the receiver cannot stall so every strobe is taken
  always @(posedge clk) begin : check_words
    word_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (pending_words.size() == 0) begin
        flag_mismatch("result strobe with no seed pending", out_valid, 0);
      end else begin
        want = pending_words.pop_front();
        words_seen++;
        if (out_hit_kept !== want.kept)
          flag_mismatch("hit_kept", out_hit_kept, want.kept);
        if (out_start_query_offset !== want.q)
          flag_mismatch("start_query_offset", out_start_query_offset, want.q);
        if (out_start_subject_offset !== want.s)
          flag_mismatch("start_subject_offset", out_start_subject_offset, want.s);
        if (out_left_extension !== want.left)
          flag_mismatch("left_extension", out_left_extension, want.left);
        if (want.kept) begin
          kept_seen++;
          if (want.left > deepest_left)
            deepest_left = want.left;
        end
      end
    end
  end

  initial begin
    cmd_t c;
    logic [6:0]  wl;
    logic [4:0]  tl;
    logic [18:0] sl;
    logic [18:0] sc;
    logic [18:0] noise;
    int qb;
    int sb;
    int d;
    int kind;
    int rand_base;
    int budget;
    int ph;
    bit fresh;

    // every input known from time zero
    rst_n                 <= 1'b0;
    start                 <= 1'b0;
    in_req_type           <= REQ_QWRITE;
    in_query_addr         <= '0;
    in_query_base         <= '0;
    in_subject_addr       <= '0;
    in_subject_byte       <= '0;
    in_hit_query_offset   <= '0;
    in_hit_subject_offset <= '0;
    cfg_we                <= 1'b0;
    cfg_index             <= CFG_WORD_LEN;
    cfg_wdata             <= '0;

    // directed table
    // reset registers: subject length and scan limit both zero
    plan_cmd(REQ_HIT, 0, 1, 1'b1, DROPPED);                // seed past the subject end
    plan_cmd(REQ_HIT, 0, 0, 1'b1, DROPPED);                // rightward run hits scan limit
    plan_cmd(REQ_HIT, 16'hFFFF, 18'h3FFFF, 1'b1, DROPPED);
    plan_cmd(REQ_NONE, 0, 0, 1'b0, DROPPED);               // ignored request code
    // short word: table length above word length, upper data bits set as noise
    plan_reg(CFG_WORD_LEN, 19'h7FF84);
    plan_reg(CFG_TABLE_LEN, 19'h7FFF0);
    plan_reg(CFG_SUBJ_LEN, 19'h40000);
    plan_reg(CFG_SCAN_LIM, 19'h0);
    plan_cmd(REQ_HIT, 16'hFFFF, 18'h3FFFF, 1'b1, kept_at(16'hFFFF, 18'h3FFFF));
    plan_cmd(REQ_HIT, 0, 0, 1'b1, kept_at(16'h0, 18'h0));
    // store corners, query code above 3 at the top entry
    plan_cmd(REQ_QWRITE, 16'hFFFF, 8'hFF, 1'b0, DROPPED);
    plan_cmd(REQ_QWRITE, 0, 8'h00, 1'b0, DROPPED);
    plan_cmd(REQ_SWRITE, 16'hFFFF, 8'hFF, 1'b0, DROPPED);
    plan_cmd(REQ_SWRITE, 0, 8'h00, 1'b0, DROPPED);
    // long word: needed count saturates, all limits wide open
    plan_reg(CFG_WORD_LEN, 19'h7F);
    plan_reg(CFG_TABLE_LEN, 19'h0);
    plan_reg(CFG_SUBJ_LEN, 19'h7FFFF);
    plan_reg(CFG_SCAN_LIM, 19'h7FFFF);
    plan_cmd(REQ_HIT, 0, 0, 1'b0, DROPPED);
    plan_cmd(REQ_HIT, 16'hFFFF, 18'h3FFFF, 1'b0, DROPPED); // runs off both stores
    plan_cmd(REQ_HIT, 40, 262100, 1'b0, DROPPED);          // query start stops the left run
    plan_cmd(REQ_HIT, 30000, 20, 1'b0, DROPPED);           // subject start stops it
    // scan limit just past the seed
    plan_reg(CFG_WORD_LEN, 19'd20);
    plan_reg(CFG_TABLE_LEN, 19'd4);
    plan_reg(CFG_SCAN_LIM, 19'd1000);
    plan_cmd(REQ_HIT, 500, 990, 1'b0, DROPPED);
    plan_cmd(REQ_HIT, 500, 200, 1'b0, DROPPED);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (i == 0 || !plan[i-1].is_reg)
          wait_idle();
        set_reg(plan[i].reg_idx, plan[i].reg_val);
      end else if (plan[i].cmd.req == REQ_HIT) begin
        send_hit(plan[i].cmd, plan[i].typed, plan[i].want);
      end else begin
        send_item(plan[i].cmd, 1'b0, DROPPED);
      end
    end

    // random part: one register setting per phase, seeds clustered on a diagonal
    rand_base = items_done;
    budget    = TOTAL_ITEMS - items_done;
    if (budget < MIN_RANDOM)
      budget = MIN_RANDOM;
    qb = 0;
    sb = 0;
    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          wl = 7'd16; tl = 5'd11; sl = 19'h7FFFF; sc = 19'h7FFFF; match_pct = 93;
        end
        1: begin
          // tight bounds, many seeds dropped on length or scan limit
          wl = 7'd20; tl = 5'd16; sl = 19'($urandom_range(100000, 262143));
          sc = 19'($urandom_range(50000, 262144)); match_pct = 90;
        end
        2: begin
          wl = 7'd64; tl = 5'd4; sl = 19'h40000; sc = 19'h40000; match_pct = 99;
        end
        3: begin
          wl = 7'd127; tl = 5'd0; sl = 19'h7FFFF; sc = 19'h7FFFF; match_pct = 99;
        end
        4: begin
          wl = 7'($urandom_range(4, 40)); tl = 5'($urandom_range(4, 16));
          sl = 19'($urandom_range(0, 19'h7FFFF)); sc = 19'($urandom_range(0, 19'h7FFFF));
          match_pct = 80;
        end
        default: begin
          wl = 7'd13; tl = 5'd9; sl = 19'h40000; sc = 19'h40000; match_pct = 70;
        end
      endcase
      noise = 19'($urandom); noise[6:0] = wl;
      set_reg(CFG_WORD_LEN, noise);
      noise = 19'($urandom); noise[4:0] = tl;
      set_reg(CFG_TABLE_LEN, noise);
      set_reg(CFG_SUBJ_LEN, sl);
      set_reg(CFG_SCAN_LIM, sc);
      fresh = 1'b1;

      while (items_done - rand_base < (budget * (ph + 1)) / PHASES) begin
        // sender gaps: 34 in a hundred, then 48, then none
        if (items_done - rand_base < budget / 3)
          idle_pct = 34;
        else if (items_done - rand_base < 2 * budget / 3)
          idle_pct = 48;
        else
          idle_pct = 0;

        // move the working window now and then, often to a sequence edge
        if (fresh || $urandom_range(99) < 8) begin
          fresh = 1'b0;
          qb = $urandom_range(0, 65535);
          sb = $urandom_range(0, 262143);
          case ($urandom_range(5))
            0: qb = $urandom_range(0, 8);
            1: sb = $urandom_range(0, 8);
            2: qb = 65535 - $urandom_range(0, 40);
            3: sb = 262143 - $urandom_range(0, 40);
            default: ;
          endcase
        end

        c    = scrambled_cmd();
        kind = $urandom_range(99);
        if (kind < 62) begin
          c.req = REQ_HIT;
          // mostly on the window diagonal, a few off it or anywhere
          if ($urandom_range(99) >= 5) begin
            d       = $urandom_range(0, 48);
            c.hit_q = 16'(qb + d);
            c.hit_s = 18'(sb + d + (($urandom_range(99) < 12) ? $urandom_range(1, 3) : 0));
          end
          send_hit(c, 1'b0, DROPPED);
        end else if (kind < 77) begin
          // query overwrite inside the window, breaks earlier matches
          c.req        = REQ_QWRITE;
          c.query_addr = 16'(qb + $urandom_range(0, 64));
          if ($urandom_range(99) < 90)
            c.query_base = 8'($urandom_range(3));
          send_item(c, 1'b0, DROPPED);
        end else if (kind < 92) begin
          c.req          = REQ_SWRITE;
          c.subject_addr = 16'((sb + $urandom_range(0, 64)) / BASES_PER_BYTE);
          send_item(c, 1'b0, DROPPED);
        end else begin
          // ignored item
          c.req = REQ_NONE;
          send_item(c, 1'b0, DROPPED);
        end
      end
    end

    // drain, then let a worst-case seed pass before the leftover check
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (pending_words.size() != 0)
      flag_mismatch("seed results never delivered", 0, pending_words.size());

    $display("sent %0d items over %0d register writes; checked %0d seed results",
             items_done, reg_writes, words_seen);
    $display("words kept %0d, dropped %0d, deepest left run %0d bases",
             kept_seen, words_seen - kept_seen, deepest_left);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
